// ----- sv/polar_gaussian_sample_gen_top_defines.svh -----
// Assertion macros for the polar Gaussian sample generator.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POLAR_GAUSSIAN_SAMPLE_GEN_TOP_DEFINES_SVH
`define POLAR_GAUSSIAN_SAMPLE_GEN_TOP_DEFINES_SVH
`ifndef SYNTH
`define PGSG_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("check failed");
`define PGSG_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("check failed");
`define PGSG_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("check failed");
`else
`define PGSG_NEVER(lbl, clk, rst_n, cond)
`define PGSG_IMPL(lbl, clk, rst_n, a, b)
`define PGSG_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- sv/pgsg_pkg.sv -----
// Shared types and constants of the polar Gaussian sample generator.
// No dependencies.
`timescale 1ns / 1ps
package pgsg_pkg;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;
	localparam int unsigned SQ_STEPS   = 24;
	localparam int unsigned DIV_STEPS  = 64;
	localparam int unsigned SQRT_STEPS = 32;

	// fraction part of 2 ln 2 in Q.32 (the integer part is added separately)
	localparam logic [30:0] LN2_FRAC_K = 31'd1659121648;
	localparam logic [31:0] FAC_ONE    = 32'd16384;
	localparam logic [15:0] SCALE_RST  = 16'd16384;
	localparam logic        DIST_RST   = 1'b1;

	localparam logic CFG_DIST_MODE = 1'b0;
	localparam logic CFG_SCALE     = 1'b1;

	typedef struct packed {
		logic        unif;
		logic [15:0] mu;
		logic [15:0] mv;
		logic        nu;
		logic        nv;
		logic        done;
		logic [29:0] s;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;
endpackage

// ----- sv/pgsg_front.sv -----
// Input stage: registers a pair, forms S = u*u + v*v and drops rejected pairs.
// Depends on pgsg_pkg.
`timescale 1ns / 1ps
module pgsg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // uniform_a, uniform_b
	input  logic                 s_axis_tlast,  // end_of_fill
	input  logic                 dist_mode,
	input  pgsg_pkg::fifo_stat_t fifo_stat,
	output logic                 push,
	output pgsg_pkg::item_t      push_item
);
	logic        valid_s1;
	logic [15:0] a_s1, b_s1;
	logic        last_s1;
	logic [15:0] mu, mv;
	logic [31:0] s_sum;
	logic        rej, drain;

	assign mu    = a_s1[15] ? (~a_s1 + 16'd1) : a_s1;
	assign mv    = b_s1[15] ? (~b_s1 + 16'd1) : b_s1;
	assign s_sum = 32'(mu) * 32'(mu) + 32'(mv) * 32'(mv);
	assign rej   = dist_mode && ((s_sum == 32'd0) || (s_sum[31:30] != 2'b00));
	assign drain = valid_s1 && (rej || !fifo_stat.full);
	assign push  = valid_s1 && !rej && !fifo_stat.full;
	assign s_axis_tready = !valid_s1 || drain;

	always_comb begin
		push_item.unif = !dist_mode;
		push_item.mu   = mu;
		push_item.mv   = mv;
		push_item.nu   = a_s1[15];
		push_item.nv   = b_s1[15];
		push_item.done = last_s1;
		push_item.s    = s_sum[29:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			a_s1    <= s_axis_tdata[15:0];
			b_s1    <= s_axis_tdata[31:16];
			last_s1 <= s_axis_tlast;
		end
	end
endmodule

// ----- sv/pgsg_fifo.sv -----
// Short queue of accepted pairs between the front and the arithmetic pipeline.
// Depends on pgsg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "polar_gaussian_sample_gen_top_defines.svh"
module pgsg_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pgsg_pkg::item_t      push_item,
	input  logic                 pop,
	output pgsg_pkg::item_t      head,
	output pgsg_pkg::fifo_stat_t stat
);
	pgsg_pkg::item_t             mem_q [pgsg_pkg::FIFO_DEPTH];
	logic [pgsg_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [pgsg_pkg::FIFO_AW:0]   cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (pgsg_pkg::FIFO_AW+1)'(pgsg_pkg::FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`PGSG_NEVER(a_no_overflow, clk, arst_n, push && stat.full)
	`PGSG_NEVER(a_no_underflow, clk, arst_n, pop && stat.empty)
	`PGSG_NEXT(a_push_fills, clk, arst_n, push && !pop, !stat.empty)
endmodule

// ----- sv/pgsg_back.sv -----
// Arithmetic pipeline: log2 by squaring, scaled division, square root, scaling
// and rounding, then a two-beat output register. Depends on pgsg_pkg and macros.
`timescale 1ns / 1ps
`include "polar_gaussian_sample_gen_top_defines.svh"
module pgsg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pgsg_pkg::fifo_stat_t fifo_stat,
	input  pgsg_pkg::item_t      fifo_head,
	output logic                 fifo_pop,
	input  logic [15:0]          scale,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,  // sample, zero padded
	output logic                 m_axis_tuser,  // second_of_pair
	output logic                 m_axis_tlast   // fill_done
);
	localparam int unsigned SQ = pgsg_pkg::SQ_STEPS;
	localparam int unsigned DV = pgsg_pkg::DIV_STEPS;
	localparam int unsigned SR = pgsg_pkg::SQRT_STEPS;

	function automatic logic [19:0] finish(input logic [47:0] x, input logic neg);
		logic [48:0] sm;
		logic [19:0] r;
		sm = {1'b0, x} + (49'd1 << 30);
		r  = {2'b00, sm[48:31]};
		if (neg) return (r > 20'd524288) ? 20'h80000 : (20'd0 - r);
		else     return (r > 20'd524287) ? 20'h7FFFF : r;
	endfunction

	logic en;
	logic pair_full_q, beat_q, done_q;
	logic [19:0] samp_a_q, samp_b_q;

	// stage 1: item from queue, normalise S
	logic            v_s1;
	pgsg_pkg::item_t it_s1;
	logic [4:0]      p1, sh1;
	logic [30:0]     m1;
	// stage 2
	logic            v_s2;
	pgsg_pkg::item_t it_s2;
	logic [4:0]      sh_s2;
	logic [30:0]     m_s2;
	// squaring steps
	logic            v_sq_s  [SQ];
	pgsg_pkg::item_t it_sq_s [SQ];
	logic [4:0]      sh_sq_s [SQ];
	logic [30:0]     m_sq_s  [SQ];
	logic [23:0]     f_sq_s  [SQ];
	// stage 3, 4: -log2 S and -2 ln S
	logic            v_s3, v_s4;
	pgsg_pkg::item_t it_s3, it_s4;
	logic [28:0]     nl_w, nl_s3;
	logic [59:0]     kp_w, kp_s3;
	logic [29:0]     t_s4;
	// division steps
	logic            v_dv_s   [DV];
	pgsg_pkg::item_t it_dv_s  [DV];
	logic [29:0]     t_dv_s   [DV];
	logic [30:0]     rem_dv_s [DV];
	logic [63:0]     q_dv_s   [DV];
	// square-root steps
	logic            v_sr_s    [SR];
	pgsg_pkg::item_t it_sr_s   [SR];
	logic [63:0]     x_sr_s    [SR];
	logic [34:0]     rem_sr_s  [SR];
	logic [31:0]     root_sr_s [SR];
	// stage 5, 6: scaling
	logic            v_s5, v_s6;
	pgsg_pkg::item_t it_s5, it_s6;
	logic [31:0]     fac5;
	logic [47:0]     pu_w, pv_w;
	logic [31:0]     pu_s5, pv_s5;
	logic [47:0]     xu_s6, xv_s6;

	assign en       = !pair_full_q || (m_axis_tready && beat_q);
	assign fifo_pop = en && !fifo_stat.empty;

	always_comb begin
		p1 = '0;
		for (int i = 0; i < 30; i++) begin
			if (it_s1.s[i]) p1 = 5'(i);
		end
	end
	assign sh1 = 5'd30 - p1;
	assign m1  = 31'(it_s1.s) << sh1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= !fifo_stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_sq_s[SQ-1];
			v_s4 <= v_s3;
			v_s5 <= v_sr_s[SR-1];
			v_s6 <= v_s5;
		end
	end

	assign nl_w = {sh_sq_s[SQ-1], 24'd0} - {5'd0, f_sq_s[SQ-1]};
	assign kp_w = 60'(nl_w) * 60'(pgsg_pkg::LN2_FRAC_K);
	assign fac5 = it_sr_s[SR-1].unif ? pgsg_pkg::FAC_ONE : root_sr_s[SR-1];
	assign pu_w = 48'(it_sr_s[SR-1].mu) * 48'(fac5);
	assign pv_w = 48'(it_sr_s[SR-1].mv) * 48'(fac5);

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= fifo_head;
			it_s2 <= it_s1;
			sh_s2 <= sh1;
			m_s2  <= m1;
			it_s3 <= it_sq_s[SQ-1];
			nl_s3 <= nl_w;
			kp_s3 <= kp_w;
			it_s4 <= it_s3;
			t_s4  <= {1'b0, nl_s3} + {2'b00, kp_s3[59:32]};
			it_s5 <= it_sr_s[SR-1];
			pu_s5 <= pu_w[31:0];
			pv_s5 <= pv_w[31:0];
			it_s6 <= it_s5;
			xu_s6 <= 48'(pu_s5) * 48'(scale);
			xv_s6 <= 48'(pv_s5) * 48'(scale);
		end
	end

	// log2 fraction: one squaring per step
	for (genvar k = 0; k < SQ; k++) begin : g_sq
		logic            vi;
		pgsg_pkg::item_t ii;
		logic [4:0]      shi;
		logic [30:0]     mi;
		logic [23:0]     fi;
		logic [61:0]     sqr;
		if (k == 0) begin : g_first
			assign vi = v_s2; assign ii = it_s2; assign shi = sh_s2;
			assign mi = m_s2; assign fi = '0;
		end else begin : g_next
			assign vi = v_sq_s[k-1]; assign ii = it_sq_s[k-1]; assign shi = sh_sq_s[k-1];
			assign mi = m_sq_s[k-1]; assign fi = f_sq_s[k-1];
		end
		assign sqr = 62'(mi) * 62'(mi);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq_s[k] <= 1'b0;
			else if (en) v_sq_s[k] <= vi;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_sq_s[k] <= ii;
				sh_sq_s[k] <= shi;
				if (sqr[61]) begin
					m_sq_s[k] <= sqr[61:31];
					f_sq_s[k] <= {fi[22:0], 1'b1};
				end else begin
					m_sq_s[k] <= sqr[60:30];
					f_sq_s[k] <= {fi[22:0], 1'b0};
				end
			end
		end
	end

	// (t << 34) / S, one quotient bit per step
	for (genvar j = 0; j < DV; j++) begin : g_dv
		logic            vi, nb, ge;
		pgsg_pkg::item_t ii;
		logic [29:0]     ti;
		logic [30:0]     ri, r, d;
		logic [63:0]     qi;
		if (j == 0) begin : g_first
			assign vi = v_s4; assign ii = it_s4; assign ti = t_s4;
			assign ri = '0; assign qi = '0;
		end else begin : g_next
			assign vi = v_dv_s[j-1]; assign ii = it_dv_s[j-1]; assign ti = t_dv_s[j-1];
			assign ri = rem_dv_s[j-1]; assign qi = q_dv_s[j-1];
		end
		if (j < 30) begin : g_tbit
			assign nb = ti[29-j];
		end else begin : g_zbit
			assign nb = 1'b0;
		end
		assign r  = {ri[29:0], nb};
		assign d  = {1'b0, ii.s};
		assign ge = (r >= d);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv_s[j] <= 1'b0;
			else if (en) v_dv_s[j] <= vi;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_dv_s[j]  <= ii;
				t_dv_s[j]   <= ti;
				rem_dv_s[j] <= ge ? (r - d) : r;
				q_dv_s[j]   <= {qi[62:0], ge};
			end
		end
	end

	// floor square root, one root bit per step
	for (genvar i = 0; i < SR; i++) begin : g_sr
		logic            vi, ge;
		pgsg_pkg::item_t ii;
		logic [63:0]     xi;
		logic [34:0]     ri, r2, trial;
		logic [31:0]     rooti;
		if (i == 0) begin : g_first
			assign vi = v_dv_s[DV-1]; assign ii = it_dv_s[DV-1]; assign xi = q_dv_s[DV-1];
			assign ri = '0; assign rooti = '0;
		end else begin : g_next
			assign vi = v_sr_s[i-1]; assign ii = it_sr_s[i-1]; assign xi = x_sr_s[i-1];
			assign ri = rem_sr_s[i-1]; assign rooti = root_sr_s[i-1];
		end
		assign r2    = {ri[32:0], xi[2*(SR-1-i)+1 -: 2]};
		assign trial = {1'b0, rooti, 2'b01};
		assign ge    = (r2 >= trial);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sr_s[i] <= 1'b0;
			else if (en) v_sr_s[i] <= vi;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_sr_s[i]   <= ii;
				x_sr_s[i]    <= xi;
				rem_sr_s[i]  <= ge ? (r2 - trial) : r2;
				root_sr_s[i] <= {rooti[30:0], ge};
			end
		end
	end

	// output register: hand out the pair as two beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_full_q <= 1'b0;
			beat_q      <= 1'b0;
		end else if (en) begin
			pair_full_q <= v_s6;
			beat_q      <= 1'b0;
		end else if (pair_full_q && m_axis_tready) begin
			beat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s6) begin
			samp_a_q <= finish(xu_s6, it_s6.nu);
			samp_b_q <= finish(xv_s6, it_s6.nv);
			done_q   <= it_s6.done;
		end
	end

	assign m_axis_tvalid = pair_full_q;
	assign m_axis_tdata  = {4'd0, beat_q ? samp_b_q : samp_a_q};
	assign m_axis_tuser  = beat_q;
	assign m_axis_tlast  = beat_q && done_q;

	`PGSG_NEVER(a_beat_needs_pair, clk, arst_n, beat_q && !pair_full_q)
	`PGSG_NEXT(a_load_first_beat, clk, arst_n, en && v_s6, pair_full_q && !beat_q)
	`PGSG_IMPL(a_pop_only_on_advance, clk, arst_n, fifo_pop, en)
endmodule

// ----- sv/polar_gaussian_sample_gen_top.sv -----
// Polar Gaussian sample generator: takes a pair of Q1.15 uniforms per input beat
// and gives two scaled samples (12 fraction bits) per pair, or none when the
// polar method rejects the pair (S >= 1 or S = 0 in normal mode). An input beat
// is taken every cycle while the four-entry queue has room; rejected pairs leave
// no output. Each kept pair leaves as two output beats on the single output
// port, and the arithmetic pipeline advances only while the output register is
// empty or its second beat is taken. The path from an input beat to the first
// output beat runs through the input register, the queue, two setup stages, the
// 24 log2 squaring steps, two log stages, 64 division steps, 32 square-root
// steps, two scaling stages and the output register. Write dist_mode and scale
// only while no pair is in flight.
// Depends on pgsg_pkg, pgsg_front, pgsg_fifo and pgsg_back.
`timescale 1ns / 1ps
module polar_gaussian_sample_gen_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // uniform_a [15:0], uniform_b [31:16]
	input  logic        s_axis_tlast,  // end_of_fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // sample [19:0], zeros above
	output logic        m_axis_tuser,  // second_of_pair
	output logic        m_axis_tlast   // fill_done
);
	logic                 dist_mode_q;
	logic [15:0]          scale_q;
	logic                 push, pop;
	pgsg_pkg::item_t      push_item, head;
	pgsg_pkg::fifo_stat_t fifo_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_mode_q <= pgsg_pkg::DIST_RST;
			scale_q     <= pgsg_pkg::SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pgsg_pkg::CFG_DIST_MODE: dist_mode_q <= cfg_data[0];
				pgsg_pkg::CFG_SCALE:     scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	pgsg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.dist_mode     (dist_mode_q),
		.fifo_stat     (fifo_stat),
		.push          (push),
		.push_item     (push_item)
	);

	pgsg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	pgsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_stat     (fifo_stat),
		.fifo_head     (head),
		.fifo_pop      (pop),
		.scale         (scale_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule
